>>> rtl/frd_pkg.sv
package frd_pkg;

    localparam int FRD_QUO_W  = 9;
    localparam int FRD_PROD_W = 17;
    localparam int FRD_DROP_W = 22;

    localparam logic [2:0] OP_WAKE     = 3'd0;
    localparam logic [2:0] OP_CAPTURE  = 3'd1;
    localparam logic [2:0] OP_STALL    = 3'd2;
    localparam logic [2:0] OP_RUNNING  = 3'd3;
    localparam logic [2:0] OP_PLAUS    = 3'd4;

    localparam logic [2:0] CFG_WAKE_LEVEL        = 3'd0;
    localparam logic [2:0] CFG_RISE_THRESHOLD    = 3'd1;
    localparam logic [2:0] CFG_RUNNING_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_WINDOW_MAX_GAIN   = 3'd3;
    localparam logic [2:0] CFG_WINDOW_MIN_GAIN   = 3'd4;

    localparam logic [7:0]            LEVEL_CAP     = 8'd253;
    localparam logic [15:0]           STALL_REF_MAX = 16'd64768;
    localparam logic [13:0]           DROP_WEIGHT   = 14'd16000;
    localparam logic [31:0]           UNIT_SCALED   = 32'd2560000000;
    localparam logic [FRD_DROP_W-1:0] NO_CONS_DROP  = 22'd10;
    localparam logic [FRD_QUO_W-1:0]  NO_CONS_UNITS = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DIV,
        ST_MUL,
        ST_APPLY
    } frd_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor_scaled;
    } frd_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FRD_QUO_W-1:0] quotient;
    } frd_div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [FRD_QUO_W-1:0] units;
        logic [7:0]           gain_max;
        logic [7:0]           gain_min;
    } frd_mul_req_t;

    typedef struct packed {
        logic                  done;
        logic [FRD_PROD_W-1:0] hi;
        logic [FRD_PROD_W-1:0] lo;
    } frd_mul_rsp_t;

endpackage

>>> rtl/frd_divider.sv
module frd_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frd_pkg::frd_div_req_t req,
    output frd_pkg::frd_div_rsp_t rsp
);
    import frd_pkg::*;

    localparam int CNT_W = $clog2(FRD_QUO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRD_QUO_W - 1);

    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          div_reg, div_next;
    logic [FRD_QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            div_next  = req.divisor_scaled;
            quo_next  = '0;
            cnt_next  = LAST_STEP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= div_reg)
            begin
                rem_next = rem_reg - div_reg;
                quo_next = {quo_reg[FRD_QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[FRD_QUO_W-2:0], 1'b0};
            end
            div_next = {1'b0, div_reg[31:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/frd_window_mul.sv
module frd_window_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frd_pkg::frd_mul_req_t req,
    output frd_pkg::frd_mul_rsp_t rsp
);
    import frd_pkg::*;

    logic [FRD_PROD_W-1:0] mcand_reg, mcand_next;
    logic [FRD_PROD_W-1:0] hi_reg, hi_next;
    logic [FRD_PROD_W-1:0] lo_reg, lo_next;
    logic [7:0]            gmax_reg, gmax_next;
    logic [7:0]            gmin_reg, gmin_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        gmax_next  = gmax_reg;
        gmin_next  = gmin_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            mcand_next = {{(FRD_PROD_W - FRD_QUO_W){1'b0}}, req.units};
            hi_next    = '0;
            lo_next    = '0;
            gmax_next  = req.gain_max;
            gmin_next  = req.gain_min;
            cnt_next   = 3'd7;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (gmax_reg[0])
            begin
                hi_next = hi_reg + mcand_reg;
            end
            if (gmin_reg[0])
            begin
                lo_next = lo_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[FRD_PROD_W-2:0], 1'b0};
            gmax_next  = {1'b0, gmax_reg[7:1]};
            gmin_next  = {1'b0, gmin_reg[7:1]};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        gmax_reg  <= gmax_next;
        gmin_reg  <= gmin_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hi   = hi_reg;
    assign rsp.lo   = lo_reg;

endmodule

>>> rtl/fuel_refill_detector.sv
// Capture, running and unused opcodes go straight from issue to apply; both rise computations
// pass through the nine-step restoring divider, and the plausibility check through the divider and
// then the eight-step shift-add multiplier, or through the multiplier alone with no consumption.
// One item is in flight at a time; the next is taken in the cycle after the result is registered.
// Asynchronous active-low reset clears control, config and output valid, but not the data registers.
module fuel_refill_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // gauge_level[7:0], engine_on[8], detect_inhibit[9], consumption_total[41:10],
    // consumption_reference[73:42], zero fill[79:74]
    input  logic [79:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // relative_rise[7:0], refill_seen[8], refill_next[9], refill_while_running[10],
    // stall_captured[11], plausibility_fault[12], zero fill[15:13]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import frd_pkg::*;

    frd_state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic [7:0]  lvl_reg;
    logic        eng_reg;
    logic        inh_reg;
    logic [31:0] ctot_reg;
    logic [31:0] cref_reg;

    logic [7:0] wake_level_reg;
    logic [7:0] rise_threshold_reg;
    logic [7:0] running_threshold_reg;
    logic [7:0] window_max_gain_reg;
    logic [7:0] window_min_gain_reg;

    logic [15:0] stall_reference_reg, stall_reference_next;
    logic [7:0]  previous_level_reg, previous_level_next;
    logic        step_above_prev_reg, step_above_prev_next;
    logic        increase_flag_reg, increase_flag_next;
    logic        next_flag_reg, next_flag_next;
    logic        running_fill_flag_reg, running_fill_flag_next;
    logic        capture_flag_reg, capture_flag_next;
    logic [7:0]  reference_level_reg, reference_level_next;
    logic [7:0]  rise_value_reg, rise_value_next;
    logic        fault_held_reg, fault_held_next;

    logic                  cons_gt_reg, cons_gt_next;
    logic                  drop_neg_reg, drop_neg_next;
    logic [FRD_DROP_W-1:0] drop_reg, drop_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    frd_div_req_t div_req;
    frd_div_rsp_t div_rsp;
    frd_mul_req_t mul_req;
    frd_mul_rsp_t mul_rsp;

    logic [7:0]  capped;
    logic [7:0]  rise_calc;
    logic [32:0] cons_diff;
    logic [8:0]  level_drop;
    logic [15:0] cur_scaled;
    logic [8:0]  run_diff;
    logic        step_now;
    logic        wake_ok;

    frd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    frd_window_mul u_window_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign capped     = (lvl_reg > LEVEL_CAP) ? LEVEL_CAP : lvl_reg;
    assign rise_calc  = div_rsp.quotient[FRD_QUO_W-1] ? 8'hFF : div_rsp.quotient[7:0];
    assign cons_diff  = {1'b0, ctot_reg} - {1'b0, cref_reg};
    assign level_drop = {1'b0, reference_level_reg} - {1'b0, lvl_reg};
    assign cur_scaled = {capped, 8'h00};
    assign run_diff   = {1'b0, capped} - {1'b0, previous_level_reg};
    assign step_now   = !run_diff[8] && (run_diff[7:0] > running_threshold_reg);
    assign wake_ok    = wake_level_reg <= LEVEL_CAP;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        state_next             = state_reg;
        stall_reference_next   = stall_reference_reg;
        previous_level_next    = previous_level_reg;
        step_above_prev_next   = step_above_prev_reg;
        increase_flag_next     = increase_flag_reg;
        next_flag_next         = next_flag_reg;
        running_fill_flag_next = running_fill_flag_reg;
        capture_flag_next      = capture_flag_reg;
        reference_level_next   = reference_level_reg;
        rise_value_next        = rise_value_reg;
        fault_held_next        = fault_held_reg;
        cons_gt_next           = cons_gt_reg;
        drop_neg_next          = drop_neg_reg;
        drop_next              = drop_reg;
        m_tvalid_next          = m_tvalid_reg && !m_tready;
        m_tdata_next           = m_tdata_reg;

        div_req.start          = 1'b0;
        div_req.dividend       = '0;
        div_req.divisor_scaled = '0;
        mul_req.start          = 1'b0;
        mul_req.units          = cons_gt_reg ? div_rsp.quotient : NO_CONS_UNITS;
        mul_req.gain_max       = window_max_gain_reg;
        mul_req.gain_min       = window_min_gain_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_APPLY;
                case (op_reg)
                    OP_WAKE:
                    begin
                        div_req.start          = 1'b1;
                        div_req.divisor_scaled = {16'h0000, wake_level_reg, 8'h00};
                        if (capped > wake_level_reg)
                        begin
                            div_req.dividend = {17'h00000, capped - wake_level_reg, 7'h00};
                        end
                        state_next = ST_DIV;
                    end
                    OP_STALL:
                    begin
                        div_req.start          = 1'b1;
                        div_req.divisor_scaled = {8'h00, stall_reference_reg, 8'h00};
                        if (cur_scaled > stall_reference_reg)
                        begin
                            div_req.dividend =
                                {9'h000, cur_scaled - stall_reference_reg, 7'h00};
                        end
                        state_next = ST_DIV;
                    end
                    OP_PLAUS:
                    begin
                        cons_gt_next  = !cons_diff[32] && (cons_diff[31:0] != 32'h0);
                        drop_neg_next = cons_gt_next && level_drop[8];
                        drop_next     = cons_gt_next
                                      ? FRD_DROP_W'(level_drop[7:0] * DROP_WEIGHT)
                                      : NO_CONS_DROP;
                        if (cons_gt_next)
                        begin
                            div_req.start          = 1'b1;
                            div_req.dividend       = cons_diff[31:0];
                            div_req.divisor_scaled = UNIT_SCALED;
                            state_next             = ST_DIV;
                        end
                        else
                        begin
                            mul_req.start = 1'b1;
                            mul_req.units = NO_CONS_UNITS;
                            state_next    = ST_MUL;
                        end
                    end
                    default:
                    begin
                        state_next = ST_APPLY;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (op_reg == OP_PLAUS)
                    begin
                        mul_req.start = 1'b1;
                        state_next    = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    case (op_reg)
                        OP_WAKE:
                        begin
                            reference_level_next = lvl_reg;
                            rise_value_next      = rise_calc;
                            if (!inh_reg && wake_ok)
                            begin
                                increase_flag_next = rise_calc > rise_threshold_reg;
                            end
                            next_flag_next = increase_flag_next && eng_reg && wake_ok;
                        end
                        OP_CAPTURE:
                        begin
                            stall_reference_next = {lvl_reg, 8'h00};
                            capture_flag_next    = 1'b1;
                            increase_flag_next   = 1'b0;
                        end
                        OP_STALL:
                        begin
                            reference_level_next = lvl_reg;
                            rise_value_next      = rise_calc;
                            if (!inh_reg && (stall_reference_reg <= STALL_REF_MAX))
                            begin
                                increase_flag_next = rise_calc > rise_threshold_reg;
                            end
                            if (!next_flag_reg && increase_flag_next && eng_reg && wake_ok)
                            begin
                                next_flag_next = 1'b1;
                            end
                        end
                        OP_RUNNING:
                        begin
                            previous_level_next  = lvl_reg;
                            step_above_prev_next = step_now;
                            if (!step_above_prev_reg && step_now)
                            begin
                                running_fill_flag_next = 1'b1;
                            end
                            if (!inh_reg && (lvl_reg <= LEVEL_CAP))
                            begin
                                increase_flag_next = step_now;
                            end
                            if (!next_flag_reg)
                            begin
                                next_flag_next = increase_flag_next;
                            end
                        end
                        OP_PLAUS:
                        begin
                            fault_held_next = drop_neg_reg
                                || !((drop_reg < FRD_DROP_W'(mul_rsp.hi))
                                     && (drop_reg > FRD_DROP_W'(mul_rsp.lo)));
                        end
                        default:
                        begin
                            fault_held_next = fault_held_reg;
                        end
                    endcase
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, fault_held_next, capture_flag_next,
                                     running_fill_flag_next, next_flag_next,
                                     increase_flag_next, rise_value_next};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            stall_reference_reg   <= '0;
            previous_level_reg    <= '0;
            step_above_prev_reg   <= 1'b0;
            increase_flag_reg     <= 1'b0;
            next_flag_reg         <= 1'b0;
            running_fill_flag_reg <= 1'b0;
            capture_flag_reg      <= 1'b0;
            reference_level_reg   <= '0;
            rise_value_reg        <= '0;
            fault_held_reg        <= 1'b0;
            m_tvalid_reg          <= 1'b0;
        end
        else
        begin
            state_reg             <= state_next;
            stall_reference_reg   <= stall_reference_next;
            previous_level_reg    <= previous_level_next;
            step_above_prev_reg   <= step_above_prev_next;
            increase_flag_reg     <= increase_flag_next;
            next_flag_reg         <= next_flag_next;
            running_fill_flag_reg <= running_fill_flag_next;
            capture_flag_reg      <= capture_flag_next;
            reference_level_reg   <= reference_level_next;
            rise_value_reg        <= rise_value_next;
            fault_held_reg        <= fault_held_next;
            m_tvalid_reg          <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_level_reg        <= '0;
            rise_threshold_reg    <= '0;
            running_threshold_reg <= '0;
            window_max_gain_reg   <= '0;
            window_min_gain_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WAKE_LEVEL:        wake_level_reg        <= cfg_data;
                CFG_RISE_THRESHOLD:    rise_threshold_reg    <= cfg_data;
                CFG_RUNNING_THRESHOLD: running_threshold_reg <= cfg_data;
                CFG_WINDOW_MAX_GAIN:   window_max_gain_reg   <= cfg_data;
                CFG_WINDOW_MIN_GAIN:   window_min_gain_reg   <= cfg_data;
                default:               wake_level_reg        <= wake_level_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            lvl_reg  <= s_tdata[7:0];
            eng_reg  <= s_tdata[8];
            inh_reg  <= s_tdata[9];
            ctot_reg <= s_tdata[41:10];
            cref_reg <= s_tdata[73:42];
        end
        cons_gt_reg  <= cons_gt_next;
        drop_neg_reg <= drop_neg_next;
        drop_reg     <= drop_next;
        m_tdata_reg  <= m_tdata_next;
    end

    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result became valid outside the apply step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished while the sequencer was not waiting for it");

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished while the sequencer was not waiting for it");

endmodule
